### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising edge outside reset
`define BIL_ASSERT(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("assertion failed");

// condition must never be seen at a rising edge outside reset
`define BIL_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, cond) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(cond)) \
		else $error("forbidden condition seen");

`else

`define BIL_ASSERT(lbl, clk_sig, rst_n_sig, prop)
`define BIL_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, cond)

`endif

`endif

### hw/rtl/bil_pkg.sv
// ---------------------------------------------------------------------------
// bil_pkg
// sizes, operation and status codes and shared types of the indexed list
// ---------------------------------------------------------------------------
`default_nettype none

package bil_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;

	// fixed field widths of the ports
	localparam int MODE_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REM_FRONT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REM_BACK  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REM_AT    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_READ      = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [IDX_W-1:0]            idx_t;
	typedef logic [CNT_W-1:0]            cnt_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		word_t wdata;
		idx_t  raddr;
	} ram_req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] word_out;
		logic [COUNT_W-1:0]        count;
		logic [STATUS_W-1:0]       status;
	} res_t;

endpackage

`default_nettype wire

### hw/rtl/bounded_indexed_list_top.sv
// ---------------------------------------------------------------------------
// bounded_indexed_list_top
// bounded ordered list of signed words with insert, remove and indexed read
// ---------------------------------------------------------------------------
// use of the block
//   input channel: in_valid/in_ready carry one request word (mode, value,
//   position); output channel: out_valid/out_ready carry one result word
//   (word_out, count, status) for every request, in request order
//   from accept, insert back, insert front into an empty list, remove back,
//   removal of the last element and every error go straight to S_FIN; a
//   read passes S_RD and S_WR first; insert front into a list of n > 0
//   words moves each word up one slot, then puts the new word in S_PUT; a
//   removal first moves m words down (m = count - 1 - position)
//   each moved word takes a read step and a write step on the single port
//   pair of the slot store, so one request is in work at a time and
//   in_ready is high again in the same cycle as that request's result shows
//   the output register lets a new request be taken while a result waits;
//   a stalled receiver holds the result and the sequencer waits in its
//   final step until the register is free
//   reset clears the count to empty; slot contents are not cleared and
//   are only ever read below the count
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_indexed_list_top
	import bil_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [MODE_W-1:0]           mode,
	input  wire logic signed [VALUE_W-1:0]   value,
	input  wire logic [POS_W-1:0]            position,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [VALUE_W-1:0]        word_out,
	output logic [COUNT_W-1:0]               count,
	output logic [STATUS_W-1:0]              status
);

	ram_req_t ram_req;
	word_t    ram_rdata;
	logic     res_valid;
	logic     res_ready;
	res_t     res;

	// output register state
	logic     out_valid_q;
	res_t     out_q;

	// slot store
	bil_slot_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// sequencer with the occupancy count
	bil_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.position  (position),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// the register takes a new result when empty or being drained this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign word_out  = out_q.word_out;
	assign count     = out_q.count;
	assign status    = out_q.status;

endmodule

`default_nettype wire

### hw/rtl/bil_slot_ram.sv
// ---------------------------------------------------------------------------
// bil_slot_ram
// slot store: one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module bil_slot_ram
	import bil_pkg::*;
(
	input  wire logic     clk,
	input  wire ram_req_t req,
	output word_t         rdata
);

	word_t mem_q [DEPTH];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/bil_ctrl.sv
// ---------------------------------------------------------------------------
// bil_ctrl
// operation sequencer: occupancy count and slot moves one word at a time
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bil_ctrl
	import bil_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [MODE_W-1:0]          mode,
	input  wire logic signed [VALUE_W-1:0]  value,
	input  wire logic [POS_W-1:0]           position,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output res_t                            res,
	output ram_req_t                        ram_req,
	input  wire word_t                      ram_rdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_WR   = 3'd2;
	localparam logic [2:0] S_PUT  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]        state_q, state_d;
	cnt_t              occ_q, occ_d;
	idx_t              ptr_q, ptr_d;
	logic [MODE_W-1:0] mode_q, mode_d;
	word_t             val_q, val_d;
	res_t              res_q, res_d;

	word_t      in_word;
	logic       pos_ok;
	logic       full;
	idx_t       rem_idx;
	logic       rem_ok;
	cnt_t       occ_dec;
	cnt_t       occ_inc;

	assign in_word = WORD_BITS'(value);
	assign pos_ok  = CMP_W'(position) < CMP_W'(occ_q);
	assign full    = occ_q == CNT_W'(DEPTH);
	assign occ_dec = occ_q - CNT_W'(1);
	assign occ_inc = occ_q + CNT_W'(1);
	assign rem_idx = (mode == MODE_REM_FRONT) ? '0 : IDX_W'(position);
	assign rem_ok  = (mode == MODE_REM_FRONT) ? (occ_q != '0) : pos_ok;

	always_comb begin
		state_d = state_q;
		occ_d   = occ_q;
		ptr_d   = ptr_q;
		mode_d  = mode_q;
		val_d   = val_q;
		res_d   = res_q;
		ram_req = '0;
		ram_req.raddr = ptr_q;
		ram_req.wdata = ram_rdata;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mode_d  = mode;
					val_d   = in_word;
					state_d = S_FIN;
					res_d   = '{word_out: '1, count: COUNT_W'(occ_q), status: STAT_RANGE};
					unique case (mode)
						MODE_INS_FRONT, MODE_INS_BACK: begin
							if (full) begin
								res_d.status = STAT_FULL;
							end else if (mode == MODE_INS_BACK || occ_q == '0) begin
								ram_req.we    = 1'b1;
								ram_req.waddr = (mode == MODE_INS_BACK) ? IDX_W'(occ_q) : '0;
								ram_req.wdata = in_word;
								occ_d = occ_inc;
								res_d = '{word_out: VALUE_W'(in_word),
									count: COUNT_W'(occ_inc), status: STAT_OK};
							end else begin
								// shift up from the last element towards the front
								ptr_d   = IDX_W'(occ_dec);
								state_d = S_RD;
							end
						end
						MODE_REM_FRONT, MODE_REM_AT: begin
							if (rem_ok) begin
								if (CNT_W'(rem_idx) == occ_dec) begin
									occ_d = occ_dec;
									res_d = '{word_out: '0, count: COUNT_W'(occ_dec),
										status: STAT_OK};
								end else begin
									ptr_d   = rem_idx + idx_t'(1);
									state_d = S_RD;
								end
							end
						end
						MODE_REM_BACK: begin
							if (occ_q != '0) begin
								occ_d = occ_dec;
								res_d = '{word_out: '0, count: COUNT_W'(occ_dec),
									status: STAT_OK};
							end
						end
						MODE_READ: begin
							if (pos_ok) begin
								ptr_d   = IDX_W'(position);
								state_d = S_RD;
							end
						end
						default: begin
							// unknown mode keeps the error result
						end
					endcase
				end
			end
			S_RD: begin
				state_d = S_WR;
			end
			S_WR: begin
				priority if (mode_q == MODE_READ) begin
					res_d   = '{word_out: VALUE_W'(ram_rdata), count: COUNT_W'(occ_q),
						status: STAT_OK};
					state_d = S_FIN;
				end else if (mode_q == MODE_INS_FRONT) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = ptr_q + idx_t'(1);
					if (ptr_q == '0) begin
						state_d = S_PUT;
					end else begin
						ptr_d   = ptr_q - idx_t'(1);
						state_d = S_RD;
					end
				end else begin
					// removal: close the gap one slot down
					ram_req.we    = 1'b1;
					ram_req.waddr = ptr_q - idx_t'(1);
					if (CNT_W'(ptr_q) == occ_dec) begin
						occ_d   = occ_dec;
						res_d   = '{word_out: '0, count: COUNT_W'(occ_dec), status: STAT_OK};
						state_d = S_FIN;
					end else begin
						ptr_d   = ptr_q + idx_t'(1);
						state_d = S_RD;
					end
				end
			end
			S_PUT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = '0;
				ram_req.wdata = val_q;
				occ_d   = occ_inc;
				res_d   = '{word_out: VALUE_W'(val_q), count: COUNT_W'(occ_inc),
					status: STAT_OK};
				state_d = S_FIN;
			end
			S_FIN: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		mode_q <= mode_d;
		val_q  <= val_d;
		res_q  <= res_d;
	end

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_FIN;
	assign res       = res_q;

	`BIL_ASSERT_NEVER(a_occ_range, clk, arst_n, occ_q > CNT_W'(DEPTH))
	`BIL_ASSERT_NEVER(a_no_write_on_read, clk, arst_n, (state_q == S_RD) && ram_req.we)
	`BIL_ASSERT(a_occ_held_in_move, clk, arst_n, (state_q == S_RD) |=> $stable(occ_q))
	`BIL_ASSERT(a_fin_held, clk, arst_n, (res_valid && !res_ready) |=> $stable(res_q))

endmodule

`default_nettype wire

### sim/bounded_indexed_list_top_tb.sv
// ---------------------------------------------------------------------------
// bounded_indexed_list_top_tb
// self-checking bench for the bounded indexed list: a shadow of the list
// predicts every result word, random idling on both channels, one long
// receiver hold-off that backs the block up into its input
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_indexed_list_top_tb;
	import bil_pkg::*;

	// codes the package leaves unnamed, both rejected by the block
	localparam logic [MODE_W-1:0] MODE_BAD_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_BAD_B = 3'd7;

	localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
	localparam word_t WORD_MIN = 32'sh8000_0000;

	localparam int RANDOM_WORDS = 1120;
	localparam int QUIET_WORDS  = 150;  // closing stretch with no idling at all
	localparam int HOLD_AT      = 500;  // random word at which the long hold starts
	localparam int HOLD_CYCLES  = 150;
	localparam int STUCK_LIMIT  = 1000; // hold-off plus slowest operation, several times over
	localparam int DRAIN_CYCLES = 40;   // outlasts the slowest operation, insert front into DEPTH - 1 words

	typedef enum int {LEAN_GROW, LEAN_SHRINK, LEAN_MIX} lean_e;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [MODE_W-1:0]         mode;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [VALUE_W-1:0] word_out;
	logic [COUNT_W-1:0]        count;
	logic [STATUS_W-1:0]       status;

	// handshakes between the sender and the result sink, and the watchdog count
	bit quiet;
	bit hold_long;
	int stuck_cycles;

	// -----------------------------------------------------------------------
	// shadow copy of the list: works out the result word of every accepted
	// request and keeps the outstanding ones in order
	// -----------------------------------------------------------------------
	class deque_shadow;
		localparam word_t NO_WORD = '1;

		word_t slot [DEPTH];
		int    fill;
		res_t  awaited [$];
		int    faults;

		function new();
			fill   = 0;
			faults = 0;
		endfunction

		task report_fault(string what);
			$display("mismatch at %0t: %s", $time, what);
			faults++;
		endtask

		// drop one element, moving the tail down by one slot
		function void close_gap(int at);
			for (int i = at; i + 1 < fill; i++)
				slot[i] = slot[i + 1];
			fill--;
		endfunction

		function void apply_request(logic [MODE_W-1:0] op, word_t val, logic [POS_W-1:0] at);
			res_t r;
			r.word_out = NO_WORD;
			r.status   = STAT_RANGE;
			case (op)
				MODE_INS_FRONT, MODE_INS_BACK: begin
					if (fill >= DEPTH) begin
						r.status = STAT_FULL;
					end else begin
						if (op == MODE_INS_FRONT) begin
							for (int i = fill; i > 0; i--)
								slot[i] = slot[i - 1];
							slot[0] = val;
						end else begin
							slot[fill] = val;
						end
						fill++;
						r.word_out = val;
						r.status   = STAT_OK;
					end
				end
				MODE_REM_FRONT: begin
					if (fill != 0) begin
						close_gap(0);
						r.word_out = '0;
						r.status   = STAT_OK;
					end
				end
				MODE_REM_BACK: begin
					if (fill != 0) begin
						fill--;
						r.word_out = '0;
						r.status   = STAT_OK;
					end
				end
				MODE_REM_AT: begin
					if (int'(at) < fill) begin
						close_gap(int'(at));
						r.word_out = '0;
						r.status   = STAT_OK;
					end
				end
				MODE_READ: begin
					if (int'(at) < fill) begin
						r.word_out = slot[at];
						r.status   = STAT_OK;
					end
				end
				default: ;
			endcase
			r.count = COUNT_W'(fill);
			awaited.push_back(r);
		endfunction

		task compare_result(word_t w, logic [COUNT_W-1:0] c, logic [STATUS_W-1:0] s);
			res_t e;
			if (awaited.size() == 0) begin
				report_fault($sformatf("result word %0d/%0d/%0d with nothing outstanding",
					w, c, s));
				return;
			end
			e = awaited.pop_front();
			if (w !== e.word_out)
				report_fault($sformatf("word_out %0d, want %0d", w, e.word_out));
			if (c !== e.count)
				report_fault($sformatf("count %0d, want %0d", c, e.count));
			if (s !== e.status)
				report_fault($sformatf("status %0d, want %0d", s, e.status));
		endtask
	endclass

	deque_shadow shadow;

	bounded_indexed_list_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.word_out  (word_out),
		.count     (count),
		.status    (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// offer one request word and hold it until taken, then maybe idle a while;
	// the shadow is told at the edge that takes the word
	task automatic offer(logic [MODE_W-1:0] op, word_t val, logic [POS_W-1:0] at);
		in_valid <= 1'b1;
		mode     <= op;
		value    <= val;
		position <= at;
		do
			@(posedge clk);
		while (!in_ready);
		shadow.apply_request(op, val, at);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// every accepted result word goes to the shadow for checking
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			shadow.compare_result(word_out, count, status);
	end

	// result sink: random stall bursts, ready stretches, one long hold on request
	initial begin : result_sink
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_long) begin
				// long hold-off counted here, the sender keeps offering meanwhile
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_long = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// watchdog: too long without any word moving on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stuck_cycles = 0;
		else if (arst_n)
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		lean_e                lean;
		int                   phase_left;
		int                   roll;
		int                   ins_w;
		int                   rem_w;
		logic [MODE_W-1:0]    op;
		word_t                val;
		logic [POS_W-1:0]     at;

		shadow       = new();
		quiet        = 1'b0;
		hold_long    = 1'b0;
		stuck_cycles = 0;
		in_valid     = 1'b0;
		mode         = MODE_INS_BACK;
		value        = '0;
		position     = '0;
		arst_n       = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---

		// removals and a read on the empty list
		offer(MODE_REM_FRONT, '0, '0);
		offer(MODE_REM_BACK, '1, 4'd15);
		offer(MODE_READ, '0, '0);
		// unused codes leave the list alone
		offer(MODE_BAD_A, 32'sd5, 4'd3);
		offer(MODE_BAD_B, -32'sd5, 4'd15);
		// taking out the only element, from the front and by index
		offer(MODE_INS_BACK, WORD_MAX, '0);
		offer(MODE_REM_FRONT, '0, '0);
		offer(MODE_INS_FRONT, WORD_MIN, '0);
		offer(MODE_REM_AT, '0, '0);
		// fill to the brim from both ends with the extreme words in the mix
		for (int i = 0; i < DEPTH; i++) begin
			case (i % 5)
				0: val = WORD_MAX;
				1: val = WORD_MIN;
				2: val = '0;
				3: val = '1;
				default: val = word_t'($urandom);
			endcase
			offer((i % 2) ? MODE_INS_FRONT : MODE_INS_BACK, val, POS_W'(i));
		end
		// insert when full is refused
		offer(MODE_INS_FRONT, 32'sd77, '0);
		// last slot, then the longest shift, then the same position out of range
		offer(MODE_READ, '0, 4'd15);
		offer(MODE_REM_AT, '0, '0);
		offer(MODE_READ, '0, 4'd15);
		offer(MODE_REM_AT, '0, 4'd15);

		// --- random part: phases that lean towards growing, shrinking or mixing ---
		phase_left = 0;
		lean       = LEAN_MIX;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == HOLD_AT)
				hold_long = 1'b1;
			if (n == RANDOM_WORDS - QUIET_WORDS)
				quiet = 1'b1;
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 40);
				case ($urandom_range(0, 2))
					0: lean = LEAN_GROW;
					1: lean = LEAN_SHRINK;
					default: lean = LEAN_MIX;
				endcase
			end
			phase_left--;

			case (lean)
				LEAN_GROW: begin
					ins_w = 65;
					rem_w = 15;
				end
				LEAN_SHRINK: begin
					ins_w = 15;
					rem_w = 65;
				end
				default: begin
					ins_w = 35;
					rem_w = 35;
				end
			endcase

			// operation, with the odd unused code thrown in
			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = $urandom_range(0, 1) ? MODE_BAD_A : MODE_BAD_B;
			else if (roll < 3 + ins_w)
				op = $urandom_range(0, 1) ? MODE_INS_FRONT : MODE_INS_BACK;
			else if (roll < 3 + ins_w + rem_w) begin
				case ($urandom_range(0, 2))
					0: op = MODE_REM_FRONT;
					1: op = MODE_REM_BACK;
					default: op = MODE_REM_AT;
				endcase
			end else
				op = MODE_READ;

			// word: mostly random bits, sometimes an extreme
			case ($urandom_range(0, 9))
				0: val = WORD_MAX;
				1: val = WORD_MIN;
				2: val = '1;
				3: val = '0;
				default: val = word_t'($urandom);
			endcase

			// position: mostly a live element, sometimes anything
			if (shadow.fill > 0 && $urandom_range(0, 4) != 0)
				at = POS_W'($urandom_range(0, shadow.fill - 1));
			else
				at = POS_W'($urandom_range(0, 15));

			offer(op, val, at);
		end
		in_valid <= 1'b0;

		// wait for the outstanding results, then give stray words a chance to show
		while (shadow.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (shadow.faults == 0 && shadow.awaited.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/bil_pkg.sv
hw/rtl/bil_slot_ram.sv
hw/rtl/bil_ctrl.sv
hw/rtl/bounded_indexed_list_top.sv
sim/bounded_indexed_list_top_tb.sv
